// ===== rtl/ppsf_pkg.sv =====
// Shared types, constants and the colour replication function for the span fill block.
// No dependencies; imported by every module of the block.
package ppsf_pkg;

	localparam int WORD_BITS      = 32;
	localparam int WORD_LSB       = 5;   // log2 of WORD_BITS
	localparam int MAX_SPAN_WORDS = 64;
	localparam int SPAN_CNT_W     = 6;   // counts 0 .. MAX_SPAN_WORDS-1
	localparam int BIT_ADDR_W     = 36;  // bit address width of the datapath
	localparam int BYTE_SHIFT     = 3;
	localparam int MAX_DEPTH_LOG2 = 5;

	// configuration register indexes
	localparam logic [2:0] REG_LINE_BYTES  = 3'd0;
	localparam logic [2:0] REG_DEPTH_LOG2  = 3'd1;
	localparam logic [2:0] REG_VIRT_WIDTH  = 3'd2;
	localparam logic [2:0] REG_VIRT_HEIGHT = 3'd3;
	localparam logic [2:0] REG_FRAME_BASE  = 3'd4;

	typedef struct packed {
		logic                first;      // first word of the span
		logic                tail;       // word holds the span end
		logic [WORD_LSB-1:0] start_off;  // bit offset of the first pixel
		logic [WORD_LSB-1:0] end_off;    // bit offset of the last affected bit
	} mask_ctl_t;

	// mask the colour to the pixel depth and repeat it across the word
	function automatic logic [WORD_BITS-1:0] replicate(input logic [31:0] color,
		input logic [2:0] depth_log2);
		logic [WORD_BITS-1:0] pat;
		pat = '0;
		case (depth_log2)
			3'd0: pat = {32{color[0]}};
			3'd1: pat = {16{color[1:0]}};
			3'd2: pat = {8{color[3:0]}};
			3'd3: pat = {4{color[7:0]}};
			3'd4: pat = {2{color[15:0]}};
			3'd5: pat = color;
			default: pat = '0;
		endcase
		return pat;
	endfunction

endpackage

// ===== rtl/ppsf_add.sv =====
// Shared bit address adder, used for every address step and the word address increment.
// Depends on ppsf_pkg.
module ppsf_add
	import ppsf_pkg::*;
(
	input  logic [BIT_ADDR_W-1:0] a,
	input  logic [BIT_ADDR_W-1:0] b,
	output logic [BIT_ADDR_W-1:0] sum
);

	assign sum = a + b;

endmodule

// ===== rtl/ppsf_mask.sv =====
// Forms the bit mask and masked data of one word operation.
// Depends on ppsf_pkg.
module ppsf_mask
	import ppsf_pkg::*;
(
	input  mask_ctl_t            ctl,
	input  logic [WORD_BITS-1:0] pattern,
	output logic [WORD_BITS-1:0] mask,
	output logic [WORD_BITS-1:0] data
);

	localparam logic [WORD_BITS-1:0] ONES = '1;

	logic [WORD_BITS-1:0] head_m;
	logic [WORD_BITS-1:0] tail_m;

	always_comb begin
		head_m = ctl.first ? (ONES << ctl.start_off) : ONES;
		tail_m = ctl.tail ? (ONES >> (WORD_LSB'(WORD_BITS - 1) - ctl.end_off)) : ONES;
		mask   = head_m & tail_m;
		data   = pattern & mask;
	end

endmodule

// ===== rtl/packed_pixel_span_fill.sv =====
// Top level of the packed pixel span fill: configuration registers, sequencer and outputs.
// Depends on ppsf_pkg, ppsf_add and ppsf_mask.
//
// One fill command is taken when start is high and busy is low. The block then works out the
// span's bit addresses (one multiply of line number and pitch, then four steps on one shared
// adder), and then gives one word operation per cycle. A command touches up to 64 words; the
// final word is on the outputs in the first cycle that busy is low again. Each result is on the
// outputs for exactly one cycle with result_valid high; the receiver cannot stall it. A command
// that is empty, clipped away or has an unsupported depth gives nothing and leaves busy low.
module packed_pixel_span_fill
	import ppsf_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        start,
	output logic        busy,
	input  logic [11:0] span_x,
	input  logic [11:0] span_y,
	input  logic [11:0] span_width,
	input  logic [31:0] fill_color,
	input  logic        action,
	output logic        result_valid,
	output logic [29:0] word_address,
	output logic [31:0] word_data,
	output logic [31:0] bit_mask,
	output logic        xor_mode,
	output logic        last_word,
	output logic        span_cut
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_BASE,
		ST_XOFF,
		ST_END,
		ST_SIZE,
		ST_EMIT
	} state_t;

	state_t state_q;

	logic [15:0] line_bytes_q;
	logic [2:0]  depth_log2_q;
	logic [12:0] virt_width_q;
	logic [12:0] virt_height_q;
	logic [31:0] frame_base_q;

	logic [11:0]           x_q;
	logic [11:0]           y_q;
	logic [12:0]           wclip_q;
	logic [WORD_BITS-1:0]  pat_q;
	logic                  op_q;
	logic [27:0]           prod_q;
	logic [BIT_ADDR_W-1:0] acc_q;
	logic [BIT_ADDR_W-1:0] start_q;
	logic [BIT_ADDR_W-1:0] end_q;
	logic [29:0]           addr_q;
	logic [SPAN_CNT_W-1:0] k_q;
	logic [SPAN_CNT_W-1:0] lastk_q;
	logic                  cut_q;
	logic [WORD_LSB-1:0]   end_off_q;

	logic        rv_q;
	logic [29:0] wa_q;
	logic [31:0] wd_q;
	logic [31:0] bm_q;
	logic        xm_q;
	logic        lw_q;
	logic        sc_q;

	logic [BIT_ADDR_W-1:0] add_a;
	logic [BIT_ADDR_W-1:0] add_b;
	logic [BIT_ADDR_W-1:0] add_sum;
	logic                  accept;
	logic                  cmd_ok;
	logic [12:0]           avail;
	logic [12:0]           wclip_d;
	logic [12:0]           diff;
	logic                  cut_d;
	mask_ctl_t             mctl;
	logic [WORD_BITS-1:0]  mask_w;
	logic [WORD_BITS-1:0]  data_w;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_bytes_q  <= 16'd1024;
			depth_log2_q  <= 3'd3;
			virt_width_q  <= 13'd640;
			virt_height_q <= 13'd480;
			frame_base_q  <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_LINE_BYTES:  line_bytes_q  <= cfg_data[15:0];
				REG_DEPTH_LOG2:  depth_log2_q  <= cfg_data[2:0];
				REG_VIRT_WIDTH:  virt_width_q  <= cfg_data[12:0];
				REG_VIRT_HEIGHT: virt_height_q <= cfg_data[12:0];
				REG_FRAME_BASE:  frame_base_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign cmd_ok = (depth_log2_q <= 3'(MAX_DEPTH_LOG2)) && (span_width != '0)
		&& ({1'b0, span_x} < virt_width_q) && ({1'b0, span_y} < virt_height_q);
	assign avail   = virt_width_q - {1'b0, span_x};
	assign wclip_d = ({1'b0, span_width} > avail) ? avail : {1'b0, span_width};

	// operand selection for the shared adder
	always_comb begin
		add_a = '0;
		add_b = '0;
		case (state_q)
			ST_BASE: begin
				add_a = {1'b0, frame_base_q[31:2], 5'b0};
				add_b = BIT_ADDR_W'({prod_q, 3'b0});
			end
			ST_XOFF: begin
				add_a = acc_q;
				add_b = BIT_ADDR_W'(x_q) << depth_log2_q;
			end
			ST_END: begin
				add_a = start_q;
				add_b = BIT_ADDR_W'(wclip_q) << depth_log2_q;
			end
			ST_SIZE: begin
				add_a = end_q;
				add_b = '1;
			end
			ST_EMIT: begin
				add_a = BIT_ADDR_W'(addr_q);
				add_b = BIT_ADDR_W'(1);
			end
			default: ;
		endcase
	end

	ppsf_add u_add (
		.a   (add_a),
		.b   (add_b),
		.sum (add_sum)
	);

	assign diff  = add_sum[WORD_LSB +: 13] - start_q[WORD_LSB +: 13];
	assign cut_d = (diff >= 13'(MAX_SPAN_WORDS));

	always_comb begin
		mctl.first     = (k_q == '0);
		mctl.tail      = !cut_q && (k_q == lastk_q);
		mctl.start_off = start_q[WORD_LSB-1:0];
		mctl.end_off   = end_off_q;
	end

	ppsf_mask u_mask (
		.ctl     (mctl),
		.pattern (pat_q),
		.mask    (mask_w),
		.data    (data_w)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rv_q    <= 1'b0;
			k_q     <= '0;
		end else begin
			rv_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept && cmd_ok) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_BASE;
				end
				ST_BASE: begin
					state_q <= ST_XOFF;
				end
				ST_XOFF: begin
					state_q <= ST_END;
				end
				ST_END: begin
					state_q <= ST_SIZE;
				end
				ST_SIZE: begin
					k_q     <= '0;
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					rv_q <= 1'b1;
					k_q  <= k_q + 1'b1;
					if (k_q == lastk_q) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				x_q     <= span_x;
				y_q     <= span_y;
				wclip_q <= wclip_d;
				pat_q   <= replicate(fill_color, depth_log2_q);
				op_q    <= action;
			end
			ST_MUL:  prod_q  <= 28'(y_q) * 28'(line_bytes_q);
			ST_BASE: acc_q   <= add_sum;
			ST_XOFF: start_q <= add_sum;
			ST_END:  end_q   <= add_sum;
			ST_SIZE: begin
				end_off_q <= add_sum[WORD_LSB-1:0];
				addr_q    <= start_q[WORD_LSB +: 30];
				cut_q     <= cut_d;
				lastk_q   <= cut_d ? SPAN_CNT_W'(MAX_SPAN_WORDS - 1) : diff[SPAN_CNT_W-1:0];
			end
			ST_EMIT: begin
				addr_q <= add_sum[29:0];
				wa_q   <= addr_q;
				wd_q   <= data_w;
				bm_q   <= mask_w;
				xm_q   <= op_q;
				lw_q   <= (k_q == lastk_q);
				sc_q   <= cut_q;
			end
			default: ;
		endcase
	end

	assign result_valid = rv_q;
	assign word_address = wa_q;
	assign word_data    = wd_q;
	assign bit_mask     = bm_q;
	assign xor_mode     = xm_q;
	assign last_word    = lw_q;
	assign span_cut     = sc_q;

	a_result_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result without a command in progress");

	a_mask_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (bit_mask != '0))
		else $error("word operation with empty mask");

	a_data_in_mask: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((word_data & ~bit_mask) == '0))
		else $error("data bits outside the mask");

	a_last_ends_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && last_word) |-> !busy || $past(accept))
		else $error("busy still high after the final word");

endmodule
